// ===== hdl/hsvc_pkg.sv =====
// Shared constants for the HSV to RGB converter.
`timescale 1ns / 1ps

package hsvc_pkg;

    localparam int FRAC_BITS_DEF = 15;
    localparam int SECTOR_W      = 3;

    localparam logic [SECTOR_W-1:0] SECTOR_RED_YEL = 3'd0;
    localparam logic [SECTOR_W-1:0] SECTOR_YEL_GRN = 3'd1;
    localparam logic [SECTOR_W-1:0] SECTOR_GRN_CYN = 3'd2;
    localparam logic [SECTOR_W-1:0] SECTOR_CYN_BLU = 3'd3;
    localparam logic [SECTOR_W-1:0] SECTOR_BLU_MAG = 3'd4;
    localparam logic [SECTOR_W-1:0] SECTOR_MAG_RED = 3'd5;

endpackage

// ===== hdl/hsvc_prep.sv =====
// Stage 1: clamp saturation and value, split six times hue into sector and fraction.
`timescale 1ns / 1ps

module hsvc_prep
    import hsvc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [FRAC_BITS-1:0]  hue,
    input  logic [FRAC_BITS:0]    saturation,
    input  logic [FRAC_BITS:0]    brightness,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SECTOR_W-1:0]   sector,
    output logic [FRAC_BITS-1:0]  frac,
    output logic [FRAC_BITS:0]    sat,
    output logic [FRAC_BITS:0]    val
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    logic                 valid_reg;
    logic                 valid_next;
    logic [SECTOR_W-1:0]  sector_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [W-1:0]         sat_reg;
    logic [W-1:0]         val_reg;
    logic [FRAC_BITS+2:0] hue_ext;
    logic [FRAC_BITS+2:0] hue6;

    // hue * 6 = hue * 4 + hue * 2
    assign hue_ext = {3'b000, hue};
    assign hue6    = (hue_ext << 2) + (hue_ext << 1);

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sector_reg <= hue6[FRAC_BITS+2:FRAC_BITS];
            frac_reg   <= hue6[FRAC_BITS-1:0];
            sat_reg    <= (saturation > ONE) ? ONE : saturation;
            val_reg    <= (brightness > ONE) ? ONE : brightness;
        end
    end

    assign out_valid = valid_reg;
    assign sector    = sector_reg;
    assign frac      = frac_reg;
    assign sat       = sat_reg;
    assign val       = val_reg;

endmodule

// ===== hdl/hsvc_mul.sv =====
// Stages 2 and 3: fixed-point products for p, s*f and s*(1-f), then q and t.
`timescale 1ns / 1ps

module hsvc_mul
    import hsvc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SECTOR_W-1:0]   sector,
    input  logic [FRAC_BITS-1:0]  frac,
    input  logic [FRAC_BITS:0]    sat,
    input  logic [FRAC_BITS:0]    val,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [SECTOR_W-1:0]   out_sector,
    output logic [FRAC_BITS:0]    out_v,
    output logic [FRAC_BITS:0]    out_p,
    output logic [FRAC_BITS:0]    out_q,
    output logic [FRAC_BITS:0]    out_t
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    // stage 2
    logic                 s2_valid_reg;
    logic                 s2_valid_next;
    logic                 s2_load;
    logic [SECTOR_W-1:0]  s2_sector_reg;
    logic [W-1:0]         s2_v_reg;
    logic [W-1:0]         s2_p_reg;
    logic [W-1:0]         s2_sf_reg;
    logic [W-1:0]         s2_sfc_reg;
    logic [2*W-1:0]       prod_p;
    logic [2*W-1:0]       prod_sf;
    logic [2*W-1:0]       prod_sfc;

    // stage 3
    logic                 s3_valid_reg;
    logic                 s3_valid_next;
    logic                 s3_load;
    logic [SECTOR_W-1:0]  s3_sector_reg;
    logic [W-1:0]         s3_v_reg;
    logic [W-1:0]         s3_p_reg;
    logic [W-1:0]         s3_q_reg;
    logic [W-1:0]         s3_t_reg;
    logic [2*W-1:0]       prod_q;
    logic [2*W-1:0]       prod_t;

    assign prod_p   = W'(val) * W'(ONE - sat);
    assign prod_sf  = W'(sat) * W'({1'b0, frac});
    assign prod_sfc = W'(sat) * W'(ONE - {1'b0, frac});

    assign prod_q = s2_v_reg * W'(ONE - s2_sf_reg);
    assign prod_t = s2_v_reg * W'(ONE - s2_sfc_reg);

    assign s3_load  = !s3_valid_reg || out_ready;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign in_ready = s2_load;

    always_comb
    begin
        s2_valid_next = s2_valid_reg;
        s3_valid_next = s3_valid_reg;
        if (s2_load)
        begin
            s2_valid_next = in_valid;
        end
        if (s3_load)
        begin
            s3_valid_next = s2_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && in_valid)
        begin
            s2_sector_reg <= sector;
            s2_v_reg      <= val;
            s2_p_reg      <= prod_p[2*W-2:FRAC_BITS];
            s2_sf_reg     <= prod_sf[2*W-2:FRAC_BITS];
            s2_sfc_reg    <= prod_sfc[2*W-2:FRAC_BITS];
        end
        if (s3_load && s2_valid_reg)
        begin
            s3_sector_reg <= s2_sector_reg;
            s3_v_reg      <= s2_v_reg;
            s3_p_reg      <= s2_p_reg;
            s3_q_reg      <= prod_q[2*W-2:FRAC_BITS];
            s3_t_reg      <= prod_t[2*W-2:FRAC_BITS];
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_sector = s3_sector_reg;
    assign out_v      = s3_v_reg;
    assign out_p      = s3_p_reg;
    assign out_q      = s3_q_reg;
    assign out_t      = s3_t_reg;

endmodule

// ===== hdl/hsvc_route.sv =====
// Stage 4: sector routing of v, p, q, t into the output register.
`timescale 1ns / 1ps

module hsvc_route
    import hsvc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [SECTOR_W-1:0]   sector,
    input  logic [FRAC_BITS:0]    v,
    input  logic [FRAC_BITS:0]    p,
    input  logic [FRAC_BITS:0]    q,
    input  logic [FRAC_BITS:0]    t,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [FRAC_BITS:0]    red,
    output logic [FRAC_BITS:0]    green,
    output logic [FRAC_BITS:0]    blue
);

    logic                 valid_reg;
    logic                 valid_next;
    logic [FRAC_BITS:0]   red_reg;
    logic [FRAC_BITS:0]   green_reg;
    logic [FRAC_BITS:0]   blue_reg;
    logic [FRAC_BITS:0]   red_next;
    logic [FRAC_BITS:0]   green_next;
    logic [FRAC_BITS:0]   blue_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        case (sector)
            SECTOR_RED_YEL:
            begin
                red_next = v; green_next = t; blue_next = p;
            end
            SECTOR_YEL_GRN:
            begin
                red_next = q; green_next = v; blue_next = p;
            end
            SECTOR_GRN_CYN:
            begin
                red_next = p; green_next = v; blue_next = t;
            end
            SECTOR_CYN_BLU:
            begin
                red_next = p; green_next = q; blue_next = v;
            end
            SECTOR_BLU_MAG:
            begin
                red_next = t; green_next = p; blue_next = v;
            end
            default:
            begin
                red_next = v; green_next = p; blue_next = q;
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign out_valid = valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

// ===== hdl/hsv_to_rgb_converter.sv =====
// A request accepted on s_ passes in order through four register stages
// (clamp/sector, p and s*f products, q and t products, routing) to m_; each
// holds one request. Throughput: one request per cycle unless m_tready stalls.
// Backpressure on m_tready stalls the stages behind it; empty stages still fill.
// Reset (rst_n low, asynchronous) clears all stage valid bits; data is not reset.
`timescale 1ns / 1ps

module hsv_to_rgb_converter
    import hsvc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          s_tvalid,
    output logic                                          s_tready,
    // hue, saturation, brightness (from bit 0), zero padded
    input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0]           s_tdata,
    output logic                                          m_tvalid,
    input  logic                                          m_tready,
    // red, green, blue (from bit 0), zero padded
    output logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0]         m_tdata
);

    localparam int W     = FRAC_BITS + 1;
    localparam int OUT_W = ((3*W+7)/8)*8;

    logic                 p1_valid;
    logic                 p1_ready;
    logic [SECTOR_W-1:0]  p1_sector;
    logic [FRAC_BITS-1:0] p1_frac;
    logic [W-1:0]         p1_sat;
    logic [W-1:0]         p1_val;

    logic                 m3_valid;
    logic                 m3_ready;
    logic [SECTOR_W-1:0]  m3_sector;
    logic [W-1:0]         m3_v;
    logic [W-1:0]         m3_p;
    logic [W-1:0]         m3_q;
    logic [W-1:0]         m3_t;

    logic [W-1:0]         red;
    logic [W-1:0]         green;
    logic [W-1:0]         blue;

    hsvc_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .hue        (s_tdata[FRAC_BITS-1:0]),
        .saturation (s_tdata[2*FRAC_BITS:FRAC_BITS]),
        .brightness (s_tdata[3*FRAC_BITS+1:2*FRAC_BITS+1]),
        .out_valid  (p1_valid),
        .out_ready  (p1_ready),
        .sector     (p1_sector),
        .frac       (p1_frac),
        .sat        (p1_sat),
        .val        (p1_val)
    );

    hsvc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (p1_valid),
        .in_ready   (p1_ready),
        .sector     (p1_sector),
        .frac       (p1_frac),
        .sat        (p1_sat),
        .val        (p1_val),
        .out_valid  (m3_valid),
        .out_ready  (m3_ready),
        .out_sector (m3_sector),
        .out_v      (m3_v),
        .out_p      (m3_p),
        .out_q      (m3_q),
        .out_t      (m3_t)
    );

    hsvc_route #(.FRAC_BITS(FRAC_BITS)) u_route (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (m3_valid),
        .in_ready   (m3_ready),
        .sector     (m3_sector),
        .v          (m3_v),
        .p          (m3_p),
        .q          (m3_q),
        .t          (m3_t),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign m_tdata = OUT_W'({blue, green, red});

endmodule

// ===== hdl/hsvc_checker.sv =====
// Port-level assertions for the HSV to RGB converter, bound to the top level.
`timescale 1ns / 1ps

module hsvc_checker
    import hsvc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    input  logic                                  s_tready,
    input  logic [((3*FRAC_BITS+2+7)/8)*8-1:0]   s_tdata,
    input  logic                                  m_tvalid,
    input  logic                                  m_tready,
    input  logic [((3*(FRAC_BITS+1)+7)/8)*8-1:0] m_tdata
);

    localparam int W = FRAC_BITS + 1;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    logic [W-1:0] red;
    logic [W-1:0] green;
    logic [W-1:0] blue;
    logic         in_unused;

    assign red       = m_tdata[W-1:0];
    assign green     = m_tdata[2*W-1:W];
    assign blue      = m_tdata[3*W-1:2*W];
    assign in_unused = ^s_tdata;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (red <= ONE) && (green <= ONE) && (blue <= ONE))
        else $error("color channel above one");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("not ready with empty output");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(s_tvalid && s_tready && !in_unused || s_tvalid && s_tready, 4)
        && $past(rst_n, 1) && $past(rst_n, 2) && $past(rst_n, 3) && $past(rst_n, 4)
        && $past(m_tready, 1) && $past(m_tready, 2) && $past(m_tready, 3)
        |-> m_tvalid)
        else $error("result missing four cycles after request");

endmodule

bind hsv_to_rgb_converter hsvc_checker #(.FRAC_BITS(FRAC_BITS)) u_hsvc_checker (.*);
